FILE: rtl/assert_macros.svh
// Assertion helpers; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/gp2js_pkg.sv
package gp2js_pkg;

  localparam logic [31:0] DeadzoneReset = 32'd171798691;
  localparam logic [7:0]  ByteReleased  = 8'hFF;
  localparam logic [16:0] StickCentre   = 17'h08000;

  // tan(11.25, 33.75, 56.25, 78.75 deg) in Q3.20
  localparam logic [22:0] TanE0 = 23'd208575;
  localparam logic [22:0] TanE1 = 23'd700636;
  localparam logic [22:0] TanE2 = 23'd1569305;
  localparam logic [22:0] TanE3 = 23'd5271548;

  localparam logic [7:0] ClrA  = 8'h40;
  localparam logic [7:0] ClrB  = 8'h84;
  localparam logic [7:0] ClrX  = 8'hA0;
  localparam logic [7:0] ClrY  = 8'h20;
  localparam logic [7:0] ClrBl = 8'h82;
  localparam logic [7:0] ClrBr = 8'h81;

  typedef struct packed {
    logic       vld;
    logic [3:0] dir;
  } dir_sel_t;

  function automatic dir_sel_t hat_to_dir(input logic [7:0] hat);
    dir_sel_t r;
    r.vld = 1'b1;
    case (hat)
      8'd1:    r.dir = 4'd12;
      8'd2:    r.dir = 4'd14;
      8'd3:    r.dir = 4'd0;
      8'd4:    r.dir = 4'd2;
      8'd5:    r.dir = 4'd4;
      8'd6:    r.dir = 4'd6;
      8'd7:    r.dir = 4'd8;
      8'd8:    r.dir = 4'd10;
      default: begin
        r.vld = 1'b0;
        r.dir = 4'd0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] dir_clear(input logic [3:0] dir);
    logic [7:0] c;
    case (dir)
      4'd0:    c = 8'h02;
      4'd1:    c = 8'h12;
      4'd2:    c = 8'h13;
      4'd3:    c = 8'h03;
      4'd4:    c = 8'h01;
      4'd5:    c = 8'h11;
      4'd6:    c = 8'h19;
      4'd7:    c = 8'h09;
      4'd8:    c = 8'h08;
      4'd9:    c = 8'h18;
      4'd10:   c = 8'h1C;
      4'd11:   c = 8'h0C;
      4'd12:   c = 8'h04;
      4'd13:   c = 8'h14;
      4'd14:   c = 8'h16;
      4'd15:   c = 8'h06;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/gamepad_to_joystick_byte.sv
// Throughput: one input word per cycle while m_axis_tready_i does not stall the output;
// stages are input register, product register
// (squares and tangent products), result register.
// Words whose byte equals the last byte sent produce no output word.
// Reset (async, active low): pipeline empty, dead zone 171798691, last byte 0xFF.
`include "assert_macros.svh"

module gamepad_to_joystick_byte (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,      // deadzone_sq
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] stick_x, [31:16] stick_y, [39:32] hat, [40] button_a, [41] button_b,
  // [42] button_x, [43] button_y, [44] bumper_left, [45] bumper_right, [47:46] zero
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // [7:0] joystick_byte
);
  import gp2js_pkg::*;

  // Dead-zone register
  logic [31:0] deadzone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= DeadzoneReset;
    end else if (cfg_we_i) begin
      deadzone_q <= cfg_wdata_i;
    end
  end

  // Handshake between stages
  logic s1_valid_q, s1_valid_d;
  logic s2_valid_q, s2_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_ready, s2_ready, s1_ready;
  logic in_acc, s2_load, out_load;

  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign s2_ready        = !s2_valid_q || out_ready;
  assign s1_ready        = !s1_valid_q || s2_ready;
  assign s_axis_tready_o = s1_ready;
  assign in_acc          = s_axis_tvalid_i && s1_ready;
  assign s2_load         = s1_valid_q && s2_ready;

  // Stage 1: input register
  logic [47:0] s1_data_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_data_q <= s_axis_tdata_i;
    end
  end

  // Stage 2 inputs: offsets, squares, tangent products
  logic signed [16:0] dx, dy;
  logic [16:0] ax, ay;
  logic [30:0] sqx_full, sqy_full;
  logic [39:0] prod_d [4];
  logic [7:0]  base_d;
  dir_sel_t    hat_d;

  always_comb begin
    dx = $signed({1'b0, s1_data_q[15:0]}) - $signed(StickCentre);
    dy = $signed({1'b0, s1_data_q[31:16]}) - $signed(StickCentre);
    ax = dx[16] ? 17'(-dx) : 17'(dx);
    ay = dy[16] ? 17'(-dy) : 17'(dy);
    sqx_full = 31'(ax) * 31'(ax);
    sqy_full = 31'(ay) * 31'(ay);
    prod_d[0] = 40'(TanE0) * 40'(ax);
    prod_d[1] = 40'(TanE1) * 40'(ax);
    prod_d[2] = 40'(TanE2) * 40'(ax);
    prod_d[3] = 40'(TanE3) * 40'(ax);
    base_d = ByteReleased;
    if (s1_data_q[40]) base_d = base_d & ~ClrA;
    if (s1_data_q[41]) base_d = base_d & ~ClrB;
    if (s1_data_q[42]) base_d = base_d & ~ClrX;
    if (s1_data_q[43]) base_d = base_d & ~ClrY;
    if (s1_data_q[44]) base_d = base_d & ~ClrBl;
    if (s1_data_q[45]) base_d = base_d & ~ClrBr;
    hat_d = hat_to_dir(s1_data_q[39:32]);
  end

  // Stage 2: product register
  logic [30:0] sqx_q, sqy_q;
  logic [39:0] prod_q [4];
  logic [16:0] ay_q;
  logic        dx_neg_q, dy_neg_q;
  logic [7:0]  base_q;
  dir_sel_t    hat_q;

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      sqx_q    <= sqx_full;
      sqy_q    <= sqy_full;
      prod_q   <= prod_d;
      ay_q     <= ay;
      dx_neg_q <= dx[16];
      dy_neg_q <= dy[16];
      base_q   <= base_d;
      hat_q    <= hat_d;
    end
  end

  // Result stage: dead-zone test, sector, byte, change detect
  logic [31:0] sq_sum;
  logic        stick_active;
  logic [39:0] lhs;
  logic [2:0]  m;
  logic [3:0]  sector;
  dir_sel_t    dir_sel;
  logic [7:0]  byte_d;
  logic [7:0]  last_sent_q;
  logic        changed;

  always_comb begin
    sq_sum       = {1'b0, sqx_q} + {1'b0, sqy_q};
    stick_active = sq_sum > deadzone_q;
    lhs          = {3'b000, ay_q, 20'd0};
    m            = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (lhs >= prod_q[i]) m = m + 3'd1;
    end
    // fold the edge count into the quadrant
    case ({dx_neg_q, dy_neg_q})
      2'b00:   sector = {1'b0, m};
      2'b10:   sector = 4'd8 - {1'b0, m};
      2'b11:   sector = 4'd8 + {1'b0, m};
      2'b01:   sector = 4'd0 - {1'b0, m};
      default: sector = 4'd0;
    endcase
    dir_sel = hat_q;
    if (stick_active) begin
      dir_sel.vld = 1'b1;
      dir_sel.dir = sector;
    end
    byte_d = base_q;
    if (dir_sel.vld) byte_d = byte_d & ~dir_clear(dir_sel.dir);
    changed = byte_d != last_sent_q;
  end

  assign out_load = s2_valid_q && out_ready && changed;

  always_comb begin
    s1_valid_d  = in_acc ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_q);
    s2_valid_d  = s2_load ? 1'b1 : (out_ready ? 1'b0 : s2_valid_q);
    out_valid_d = out_load ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);
  end

  // last byte sent doubles as the output data register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_sent_q <= ByteReleased;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      if (out_load) last_sent_q <= byte_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = last_sent_q;

  `ASSERT_CLK(a_full_when_blocked, clk_i, rst_ni, !s_axis_tready_o |-> (s1_valid_q && s2_valid_q && out_valid_q))
  `ASSERT_CLK(a_result_from_stage2, clk_i, rst_ni, $rose(out_valid_q) |-> $past(s2_valid_q))
  `ASSERT_CLK(a_last_stable_on_stall, clk_i, rst_ni, (out_valid_q && !m_axis_tready_i) |=> $stable(last_sent_q))
  `ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> (!s1_valid_q && !s2_valid_q && !out_valid_q))

endmodule
